// ===== sv/thin_lens_ray_deflect_macros.svh =====
// Assertion helpers shared by the RTL. They compile to nothing in synthesis.
`ifndef THIN_LENS_RAY_DEFLECT_MACROS_SVH
`define THIN_LENS_RAY_DEFLECT_MACROS_SVH
`ifndef SYNTHESIS
`define TLRD_ASSERT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TLRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TLRD_ASSERT(label, clk, rstn, ante, cons)
`define TLRD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/tlrd_pkg.sv =====
package tlrd_pkg;

  localparam int unsigned DIV_NUM_W  = 63;
  localparam int unsigned DIV_DEN_W  = 32;
  localparam int unsigned DIV_QUO_W  = 33;
  localparam int unsigned FIX_W      = DIV_QUO_W + 2;
  localparam int unsigned SAT_W      = 40;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned SQ_W       = 2 * SQRT_STEPS;
  localparam int unsigned REM_W      = SQRT_STEPS + 2;
  localparam int unsigned DIR_FRAC   = 30;
  localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    REG_PLANE_X,
    REG_APERTURE,
    REG_FOCAL,
    REG_LENS_ON
  } cfg_reg_e;

  // Ray as it enters the first divider bank, with the quotient signs.
  typedef struct packed {
    logic        zdx;
    logic        s_dist;
    logic        s_ty;
    logic        s_tz;
    logic        s_ft;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [31:0] path;
  } ray_t;

  // Ray after it reached the lens plane.
  typedef struct packed {
    logic             zdx;
    logic             miss;
    logic             lz;
    logic [31:0]      npx;
    logic [31:0]      npy;
    logic [31:0]      npz;
    logic [31:0]      dx;
    logic [31:0]      dy;
    logic [31:0]      dz;
    logic [31:0]      path;
    logic [FIX_W-1:0] ft;
    logic [31:0]      nx;
    logic [31:0]      ny;
    logic [31:0]      nz;
  } late_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [31:0] path;
  } out_t;

  // Signed quotient from magnitude; an overflowed quotient is clamped to
  // plus or minus 2^QUO_W, which still saturates every later sum correctly.
  function automatic logic signed [FIX_W-1:0] div_fix(logic [DIV_QUO_W-1:0] mag,
                                                      logic ovf, logic neg);
    logic [FIX_W-1:0]        m;
    logic signed [FIX_W-1:0] r;
    m = ovf ? (FIX_W'(1) << DIV_QUO_W) : FIX_W'(mag);
    r = $signed(m);
    return neg ? -r : r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [SAT_W-1:0] v);
    if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) begin
      return v[31:0];
    end else if (v[SAT_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

// ===== sv/tlrd_div.sv =====
module tlrd_div import tlrd_pkg::*; #(
  parameter int unsigned NUM_W = DIV_NUM_W,
  parameter int unsigned DEN_W = DIV_DEN_W,
  parameter int unsigned QUO_W = DIV_QUO_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic             ovf_q [QUO_W];

  logic [NUM_W-QUO_W-1:0] high;
  logic                   ovf_first;

  assign high = num_i[NUM_W-1:QUO_W];
  // The quotient does not fit in QUO_W bits when the upper part alone reaches the divisor.
  assign ovf_first = NUM_W'(high) >= NUM_W'(den_i);

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic             ovf_in;
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = DEN_W'(high);
      assign den_in = den_i;
      assign low_in = num_i[QUO_W-1:0];
      assign quo_in = '0;
      assign ovf_in = ovf_first;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    assign t    = {rem_in, low_in[QUO_W-1-s]};
    assign diff = t - {1'b0, den_in};
    assign ge   = t >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        den_q[s] <= den_in;
        low_q[s] <= low_in;
        quo_q[s] <= quo_in | (QUO_W'(ge) << (QUO_W-1-s));
        ovf_q[s] <= ovf_in;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
  assign ovf_o = ovf_q[QUO_W-1];

endmodule

// ===== sv/thin_lens_ray_deflect.sv =====
// Thin-lens ray deflection. A ray beat is accepted on every cycle in which
// in_ready_o is high; with the output taken, one ray per cycle is sustained. The
// pipeline holds two banks of 33-stage restoring dividers (distance and lens
// terms by |dir_x|, then normalization by the ray length) with the 32-stage
// square root between them. An output register with one skid entry lets
// the pipeline keep moving while a result waits; when the skid entry is
// full the whole pipeline holds. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i and must only change while no ray is in flight.
`include "thin_lens_ray_deflect_macros.svh"

module thin_lens_ray_deflect import tlrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [62:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] dir_x_i,
  input  logic [31:0] dir_y_i,
  input  logic [31:0] dir_z_i,
  input  logic [31:0] path_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [31:0] out_pos_x_o,
  output logic [31:0] out_pos_y_o,
  output logic [31:0] out_pos_z_o,
  output logic [31:0] out_dir_x_o,
  output logic [31:0] out_dir_y_o,
  output logic [31:0] out_dir_z_o,
  output logic [31:0] path_out_o
);

  localparam int unsigned QW = DIV_QUO_W;

  // Configuration registers.
  logic [31:0] plane_x_q;
  logic [62:0] aperture_q;
  logic [31:0] focal_q;
  logic        lens_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_x_q  <= '0;
      aperture_q <= '0;
      focal_q    <= FOCAL_RESET;
      lens_on_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PLANE_X:  plane_x_q  <= cfg_data_i[31:0];
        REG_APERTURE: aperture_q <= cfg_data_i;
        REG_FOCAL:    focal_q    <= cfg_data_i[31:0];
        REG_LENS_ON:  lens_on_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic skid_valid_q;
  logic out_valid_q;

  assign adv        = !skid_valid_q;
  assign in_ready_o = adv;

  // Stage 1: plane offset, lens products and divider operands.
  logic signed [32:0] diff_c;
  logic signed [63:0] py_c;
  logic signed [63:0] pz_c;
  logic [31:0]        adiff_c;
  logic [62:0]        apy_c;
  logic [62:0]        apz_c;
  logic               pdx_c;
  ray_t               ray_c;

  assign diff_c  = $signed({plane_x_q[31], plane_x_q}) - $signed({pos_x_i[31], pos_x_i});
  assign adiff_c = diff_c[32] ? 32'(-diff_c) : diff_c[31:0];
  assign py_c    = $signed(dir_y_i) * $signed(focal_q);
  assign pz_c    = $signed(dir_z_i) * $signed(focal_q);
  assign apy_c   = py_c[63] ? 63'(-py_c) : py_c[62:0];
  assign apz_c   = pz_c[63] ? 63'(-pz_c) : pz_c[62:0];
  // The lens terms divide by -dir_x, which is negative for a positive dir_x.
  assign pdx_c   = !dir_x_i[31];

  always_comb begin
    ray_c.zdx    = dir_x_i == 32'd0;
    ray_c.s_dist = diff_c[32] ^ dir_x_i[31];
    ray_c.s_ty   = py_c[63] ^ pdx_c;
    ray_c.s_tz   = pz_c[63] ^ pdx_c;
    ray_c.s_ft   = focal_q[31] ^ pdx_c;
    ray_c.px     = pos_x_i;
    ray_c.py     = pos_y_i;
    ray_c.pz     = pos_z_i;
    ray_c.dx     = dir_x_i;
    ray_c.dy     = dir_y_i;
    ray_c.dz     = dir_z_i;
    ray_c.path   = path_in_i;
  end

  logic                 v1_q;
  ray_t                 ray1_q;
  logic [DIV_NUM_W-1:0] num1_q [4];
  logic [DIV_DEN_W-1:0] den1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray1_q    <= ray_c;
      num1_q[0] <= {1'b0, adiff_c, DIR_FRAC'(0)};
      num1_q[1] <= apy_c;
      num1_q[2] <= apz_c;
      num1_q[3] <= {1'b0, abs32(focal_q), DIR_FRAC'(0)};
      den1_q    <= abs32(dir_x_i);
    end
  end

  logic [QW-1:0] q1 [4];
  logic [3:0]    o1;

  for (genvar g = 0; g < 4; g++) begin : g_div1
    tlrd_div #(
      .NUM_W(DIV_NUM_W),
      .DEN_W(DIV_DEN_W),
      .QUO_W(QW)
    ) u_div (
      .clk_i(clk_i),
      .en_i (adv),
      .num_i(num1_q[g]),
      .den_i(den1_q),
      .quo_o(q1[g]),
      .ovf_o(o1[g])
    );
  end

  ray_t          rd_q [QW];
  logic [QW-1:0] vd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q[0] <= ray1_q;
      for (int i = 1; i < QW; i++) begin
        rd_q[i] <= rd_q[i-1];
      end
    end
  end

  // Stage 2: signed quotients.
  ray_t                    ray2_q;
  logic [31:0]             dist2_q;
  logic signed [FIX_W-1:0] ty2_q;
  logic signed [FIX_W-1:0] tz2_q;
  logic signed [FIX_W-1:0] ft2_q;
  logic                    v2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray2_q  <= rd_q[QW-1];
      dist2_q <= sat32(SAT_W'(div_fix(q1[0], o1[0], rd_q[QW-1].s_dist)));
      ty2_q   <= div_fix(q1[1], o1[1], rd_q[QW-1].s_ty);
      tz2_q   <= div_fix(q1[2], o1[2], rd_q[QW-1].s_tz);
      ft2_q   <= div_fix(q1[3], o1[3], rd_q[QW-1].s_ft);
    end
  end

  // Stage 3: travel products and path.
  ray_t                    ray3_q;
  logic signed [63:0]      prod3_q [3];
  logic [31:0]             path3_q;
  logic signed [FIX_W-1:0] ty3_q;
  logic signed [FIX_W-1:0] tz3_q;
  logic signed [FIX_W-1:0] ft3_q;
  logic                    v3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray3_q     <= ray2_q;
      prod3_q[0] <= $signed(dist2_q) * $signed(ray2_q.dx);
      prod3_q[1] <= $signed(dist2_q) * $signed(ray2_q.dy);
      prod3_q[2] <= $signed(dist2_q) * $signed(ray2_q.dz);
      path3_q    <= ray2_q.zdx ? ray2_q.path :
                    sat32(SAT_W'($signed(ray2_q.path)) + SAT_W'($signed(dist2_q)));
      ty3_q      <= ty2_q;
      tz3_q      <= tz2_q;
      ft3_q      <= ft2_q;
    end
  end

  // Stage 4: position on the plane. A ray parallel to the plane keeps its position.
  late_t                   late4_c;
  late_t                   late4_q;
  logic signed [FIX_W-1:0] ty4_q;
  logic signed [FIX_W-1:0] tz4_q;
  logic                    v4_q;

  always_comb begin
    late4_c      = '0;
    late4_c.zdx  = ray3_q.zdx;
    late4_c.npx  = ray3_q.zdx ? ray3_q.px :
                   sat32(SAT_W'($signed(ray3_q.px)) + SAT_W'(prod3_q[0] >>> DIR_FRAC));
    late4_c.npy  = ray3_q.zdx ? ray3_q.py :
                   sat32(SAT_W'($signed(ray3_q.py)) + SAT_W'(prod3_q[1] >>> DIR_FRAC));
    late4_c.npz  = ray3_q.zdx ? ray3_q.pz :
                   sat32(SAT_W'($signed(ray3_q.pz)) + SAT_W'(prod3_q[2] >>> DIR_FRAC));
    late4_c.dx   = ray3_q.dx;
    late4_c.dy   = ray3_q.dy;
    late4_c.dz   = ray3_q.dz;
    late4_c.path = path3_q;
    late4_c.ft   = ft3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      late4_q <= late4_c;
      ty4_q   <= ty3_q;
      tz4_q   <= tz3_q;
    end
  end

  // Stage 5: aperture squares and the unnormalized new direction.
  late_t       late5_c;
  late_t       late5_q;
  logic [63:0] sqy5_q;
  logic [63:0] sqz5_q;
  logic        v5_q;

  always_comb begin
    late5_c    = late4_q;
    late5_c.nx = sat32(-SAT_W'($signed(focal_q)));
    late5_c.ny = sat32(SAT_W'(ty4_q) - SAT_W'($signed(late4_q.npy)));
    late5_c.nz = sat32(SAT_W'(tz4_q) - SAT_W'($signed(late4_q.npz)));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      late5_q <= late5_c;
      sqy5_q  <= abs32(late4_q.npy) * abs32(late4_q.npy);
      sqz5_q  <= abs32(late4_q.npz) * abs32(late4_q.npz);
    end
  end

  // Stage 6: aperture test and squares of the new direction.
  late_t       late6_c;
  late_t       late6_q;
  logic [63:0] sqn6_q [3];
  logic        v6_q;

  always_comb begin
    late6_c      = late5_q;
    late6_c.miss = ({1'b0, sqy5_q} + {1'b0, sqz5_q}) > {2'b00, aperture_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      late6_q   <= late6_c;
      sqn6_q[0] <= abs32(late5_q.nx) * abs32(late5_q.nx);
      sqn6_q[1] <= abs32(late5_q.ny) * abs32(late5_q.ny);
      sqn6_q[2] <= abs32(late5_q.nz) * abs32(late5_q.nz);
    end
  end

  // Stage 7: squared length.
  late_t          late7_q;
  logic [SQ_W-1:0] sq7_q;
  logic            v7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      late7_q <= late6_q;
      sq7_q   <= sqn6_q[0] + sqn6_q[1] + sqn6_q[2];
    end
  end

  // Square root, one result bit per stage.
  logic [REM_W-1:0]      sq_rem_q  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_root_q [SQRT_STEPS];
  logic [SQ_W-1:0]       sq_val_q  [SQRT_STEPS];
  late_t                 sq_late_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sv_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0]      rem_in;
    logic [SQRT_STEPS-1:0] root_in;
    logic [SQ_W-1:0]       val_in;
    late_t                 late_in;
    logic [REM_W+1:0]      t;
    logic [REM_W+1:0]      trial;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = sq7_q;
      assign late_in = late7_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign val_in  = sq_val_q[k-1];
      assign late_in = sq_late_q[k-1];
    end

    assign t     = {rem_in, val_in[SQ_W-1-2*k -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k]  <= ge ? REM_W'(t - trial) : t[REM_W-1:0];
        sq_root_q[k] <= {root_in[SQRT_STEPS-2:0], ge};
        sq_val_q[k]  <= val_in;
        sq_late_q[k] <= late_in;
      end
    end
  end

  // Stage 8: final path length.
  late_t                 late8_c;
  late_t                 late8_q;
  logic [SQRT_STEPS-1:0] len_c;
  logic [SQRT_STEPS-1:0] len8_q;
  logic                  v8_q;

  assign len_c = sq_root_q[SQRT_STEPS-1];

  always_comb begin
    late8_c    = sq_late_q[SQRT_STEPS-1];
    late8_c.lz = len_c == '0;
    if (lens_on_q && !late8_c.miss && !late8_c.zdx) begin
      late8_c.path = sat32(SAT_W'($signed(late8_c.path)) + SAT_W'($signed(late8_c.ft))
                           - SAT_W'($signed({1'b0, len_c})));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      late8_q <= late8_c;
      len8_q  <= len_c;
    end
  end

  // Normalization dividers.
  logic [31:0]   n8 [3];
  logic [QW-1:0] q2 [3];
  logic [2:0]    o2;

  assign n8[0] = late8_q.nx;
  assign n8[1] = late8_q.ny;
  assign n8[2] = late8_q.nz;

  for (genvar g = 0; g < 3; g++) begin : g_div2
    tlrd_div #(
      .NUM_W(DIV_NUM_W),
      .DEN_W(DIV_DEN_W),
      .QUO_W(QW)
    ) u_div (
      .clk_i(clk_i),
      .en_i (adv),
      .num_i({1'b0, abs32(n8[g]), DIR_FRAC'(0)}),
      .den_i(DIV_DEN_W'(len8_q)),
      .quo_o(q2[g]),
      .ovf_o(o2[g])
    );
  end

  late_t         dl_q [QW];
  logic [QW-1:0] dv_q;
  logic [31:0]   nd_q [QW][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0] <= late8_q;
      nd_q[0] <= n8;
      for (int i = 1; i < QW; i++) begin
        dl_q[i] <= dl_q[i-1];
        nd_q[i] <= nd_q[i-1];
      end
    end
  end

  // Result selection.
  late_t       fin;
  logic [31:0] dir_c [3];
  logic        use_new;
  out_t        res_c;

  assign fin = dl_q[QW-1];

  for (genvar g = 0; g < 3; g++) begin : g_dir
    assign dir_c[g] = nd_q[QW-1][g][31] ? (32'd0 - q2[g][31:0]) : q2[g][31:0];
  end

  assign use_new = lens_on_q && !fin.miss && !fin.zdx && !fin.lz;

  always_comb begin
    res_c.hit  = !fin.zdx && !(lens_on_q && fin.miss);
    res_c.px   = fin.npx;
    res_c.py   = fin.npy;
    res_c.pz   = fin.npz;
    res_c.dx   = use_new ? dir_c[0] : fin.dx;
    res_c.dy   = use_new ? dir_c[1] : fin.dy;
    res_c.dz   = use_new ? dir_c[2] : fin.dz;
    res_c.path = fin.path;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vd_q <= '0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      sv_q <= '0;
      v8_q <= 1'b0;
      dv_q <= '0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      vd_q <= {vd_q[QW-2:0], v1_q};
      v2_q <= vd_q[QW-1];
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      sv_q <= {sv_q[SQRT_STEPS-2:0], v7_q};
      v8_q <= sv_q[SQRT_STEPS-1];
      dv_q <= {dv_q[QW-2:0], v8_q};
    end
  end

  // Output register with one skid entry.
  out_t out_q;
  out_t skid_q;
  logic arrive;

  assign arrive = adv && dv_q[QW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (arrive) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (arrive) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res_c;
      end else begin
        out_q <= res_c;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_q.hit;
  assign out_pos_x_o = out_q.px;
  assign out_pos_y_o = out_q.py;
  assign out_pos_z_o = out_q.pz;
  assign out_dir_x_o = out_q.dx;
  assign out_dir_y_o = out_q.dy;
  assign out_dir_z_o = out_q.dz;
  assign path_out_o  = out_q.path;

  // The length is at least each component, so normalized quotients stay in range.
  `TLRD_ASSERT(a_norm_in_range, clk_i, rst_ni, dv_q[QW-1] && !fin.lz, o2 == 3'b000)
  `TLRD_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `TLRD_ASSERT_NEXT(a_skid_fills_on_stall, clk_i, rst_ni,
                    arrive && out_valid_q && !out_ready_i, skid_valid_q)

endmodule

// ===== bench/thin_lens_ray_deflect_test.sv =====
module thin_lens_ray_deflect_test;
  import tlrd_pkg::*;

  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [31:0] path;
  } ray_beat_t;

  class lens_scoreboard;
    longint          plane;
    longint unsigned aper_sq;
    longint          focal;
    bit              lens_en;
    out_t            pending[$];
    int              errors;

    function new();
      plane   = 0;
      aper_sq = 0;
      focal   = 65536;
      lens_en = 0;
      errors  = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [62:0] val);
      case (idx)
        REG_PLANE_X:  plane   = longint'($signed(val[31:0]));
        REG_APERTURE: aper_sq = {1'b0, val};
        REG_FOCAL:    focal   = longint'($signed(val[31:0]));
        default:      lens_en = val[0];
      endcase
    endfunction

    function logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function out_t deflect(ray_beat_t r);
      out_t            o;
      longint          p[3], d[3], np[3], n[3];
      longint          travel, path1, negdx, fterm;
      longint unsigned ay, az, sq, len, a;
      p[0] = $signed(r.px); p[1] = $signed(r.py); p[2] = $signed(r.pz);
      d[0] = $signed(r.dx); d[1] = $signed(r.dy); d[2] = $signed(r.dz);
      o = '{hit: 1'b0, px: r.px, py: r.py, pz: r.pz, dx: r.dx, dy: r.dy, dz: r.dz,
            path: r.path};
      if (d[0] == 0) return o;
      travel = $signed(clip32(((plane - p[0]) * ONE_Q30) / d[0]));
      for (int i = 0; i < 3; i++) np[i] = $signed(clip32(p[i] + ((travel * d[i]) >>> 30)));
      path1 = $signed(clip32(longint'($signed(r.path)) + travel));
      o.hit = 1'b1;
      o.px = np[0][31:0]; o.py = np[1][31:0]; o.pz = np[2][31:0];
      o.path = path1[31:0];
      if (!lens_en) return o;
      ay = (np[1] < 0) ? -np[1] : np[1];
      az = (np[2] < 0) ? -np[2] : np[2];
      if (ay * ay + az * az > aper_sq) begin
        o.hit = 1'b0;
        return o;
      end
      negdx = -d[0];
      n[0] = $signed(clip32(-focal));
      n[1] = $signed(clip32((d[1] * focal) / negdx - np[1]));
      n[2] = $signed(clip32((d[2] * focal) / negdx - np[2]));
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        a = (n[i] < 0) ? -n[i] : n[i];
        sq += a * a;
      end
      len = root64(sq);
      fterm = (focal * ONE_Q30) / negdx;
      o.path = clip32(path1 + fterm - longint'(len));
      // A degenerate bent direction keeps the incoming one.
      if (len != 0) begin
        o.dx = 32'((n[0] * ONE_Q30) / longint'(len));
        o.dy = 32'((n[1] * ONE_Q30) / longint'(len));
        o.dz = 32'((n[2] * ONE_Q30) / longint'(len));
      end
      return o;
    endfunction

    function void note(ray_beat_t r);
      pending.push_back(deflect(r));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task field(string nm, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", nm, got, want));
    endtask

    task check(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = pending.pop_front();
      field("hit", 32'(got.hit), 32'(want.hit));
      field("pos_x", got.px, want.px);
      field("pos_y", got.py, want.py);
      field("pos_z", got.pz, want.pz);
      field("dir_x", got.dx, want.dx);
      field("dir_y", got.dy, want.dy);
      field("dir_z", got.dz, want.dz);
      field("path", got.path, want.path);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [62:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  ray_beat_t   ray_in = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        res;

  lens_scoreboard sb = new();
  bit calm = 1'b0;
  int hold_req = 0;
  int n_sent = 0;
  int n_hits = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  thin_lens_ray_deflect i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .pos_x_i(ray_in.px), .pos_y_i(ray_in.py), .pos_z_i(ray_in.pz),
    .dir_x_i(ray_in.dx), .dir_y_i(ray_in.dy), .dir_z_i(ray_in.dz),
    .path_in_i(ray_in.path),
    .out_valid_o, .out_ready_i,
    .hit_o(res.hit), .out_pos_x_o(res.px), .out_pos_y_o(res.py), .out_pos_z_o(res.pz),
    .out_dir_x_o(res.dx), .out_dir_y_o(res.dy), .out_dir_z_o(res.dz),
    .path_out_o(res.path)
  );

  // Result side: checks at the rising edge, decides ready at the falling edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (res.hit) n_hits++;
        sb.check(res);
      end
      @(negedge clk_i);
      if (hold_req > 0) begin
        out_ready_i = 1'b0;
        hold_req--;
      end else begin
        out_ready_i = calm || ($urandom_range(99) >= 14);
      end
    end
  end

  task write_reg(cfg_reg_e idx, logic [62:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task setup(logic [31:0] pl, logic [62:0] ap, logic [31:0] fl, bit on);
    write_reg(REG_PLANE_X, {31'd0, pl});
    write_reg(REG_APERTURE, ap);
    write_reg(REG_FOCAL, {31'd0, fl});
    write_reg(REG_LENS_ON, {62'd0, on});
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task send(ray_beat_t r);
    if (!calm && $urandom_range(99) < 14) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    ray_in = r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(r);
    n_sent++;
  endtask

  // Waits until every outstanding result is back, then lets the pipeline empty.
  task drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function logic [31:0] srand(int unsigned mag);
    logic [31:0] v;
    v = $urandom_range(mag);
    return $urandom_range(1) ? -v : v;
  endfunction

  function ray_beat_t rand_ray();
    ray_beat_t r;
    if ($urandom_range(99) < 15) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      r.dx = $urandom_range(1 << 30, 1 << 27);
      if ($urandom_range(1)) r.dx = -r.dx;
      r.dy = srand(1 << 29);
      r.dz = srand(1 << 29);
      r.px = srand(1 << 22);
      r.py = srand(1 << 20);
      r.pz = srand(1 << 20);
      r.path = srand(1 << 24);
    end
    return r;
  endfunction

  function ray_beat_t mk(logic [31:0] px, py, pz, dx, dy, dz, pa);
    return '{px: px, py: py, pz: pz, dx: dx, dy: dy, dz: dz, path: pa};
  endfunction

  task rand_phase(int cnt);
    logic [31:0] rad;
    rad = $urandom_range(1 << 20);
    setup(srand(1 << 22), 63'(rad) * 63'(rad), srand(1 << 21), 1'b1);
    repeat (cnt) send(rand_ray());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: lens off, pure propagation.
    send(mk(32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000, 0, 0, 0));
    send(mk(32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send(mk(32'h7fff_ffff, 5, 6, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    send(mk(32'h1234_5678, 1, 2, 32'h0, 32'h2000_0000, 32'h1, 32'h55));
    drain();
    // Lens on with tight aperture: misses and hits on axis.
    setup(32'h0004_0000, 63'h1_0000_0000, 32'h0002_0000, 1'b1);
    send(mk(0, 0, 0, 32'h4000_0000, 0, 0, 0));
    send(mk(0, 32'h0010_0000, 0, 32'h4000_0000, 0, 0, 0));
    send(mk(0, 32'h8000, 32'h8000, 32'hc000_0000, 32'h100_0000, 32'hff00_0000, 32'h7fff_0000));
    send(mk(0, 0, 0, 32'h0, 32'hffff_ffff, 0, 32'h8000_0000));
    drain();
    // Zero focal length on axis gives a zero-length new direction.
    setup(32'h0004_0000, 63'h7fff_ffff_ffff_ffff, 32'h0, 1'b1);
    send(mk(0, 0, 0, 32'h4000_0000, 0, 0, 32'h100));
    send(mk(0, 0, 0, 32'hc000_0000, 0, 0, 32'h100));
    send(mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0));
    drain();
    setup(32'h7fff_ffff, 63'h7fff_ffff_ffff_ffff, 32'h7fff_ffff, 1'b1);
    send(mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7fff_ffff, 0));
    send(mk(32'h8000_0000, 3, 4, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send(mk(0, 0, 0, 32'h8000_0000, 32'h4000_0000, 32'hc000_0000, 32'h8000_0000));
    drain();
    setup(32'h8000_0000, 63'h0, 32'h8000_0000, 1'b1);
    send(mk(32'h7fff_ffff, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    send(mk(0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send(mk(32'h7fff_ffff, 32'h1, 0, 32'h8000_0000, 0, 0, 0));
    drain();

    // Back-to-back stretch with the result side held off so the pipeline fills.
    calm = 1'b1;
    setup(srand(1 << 22), 63'h0000_0100_0000_0000, 32'h0003_0000, 1'b1);
    hold_req = 400;
    repeat (200) send(rand_ray());
    drain();
    calm = 1'b0;

    rand_phase(200);
    setup(32'h0, 63'h7fff_ffff_ffff_ffff, 32'hfffd_0000, 1'b0);
    repeat (100) send(rand_ray());
    drain();
    rand_phase(120);
    rand_phase(110);

    $display("covered %0d rays over several lens settings, %0d hits", n_sent, n_hits);
    $display("included a full-pipeline stall and zero-direction, miss and degenerate rays");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
